// File: rtl/core/assert_macros.svh
// Assertion macros shared by the sliding-window RMS RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define SWR_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SWR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SWR_ASSERT_IMPLY(name, clk, rst, ante, cons)

`define SWR_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/swr_pkg.sv
// Shared types, constants and helpers of the sliding-window RMS core.
package swr_pkg;

  localparam int SMP_W          = 16;
  localparam int RMS_W          = 16;
  localparam int WIN_W          = 9;
  localparam int SQ_W           = 31;
  localparam int ROOT_STEPS     = 16;
  localparam int DEF_MAX_WINDOW = 256;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  localparam logic [WIN_W-1:0] WIN_RESET = 9'd16;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic accept;
    logic square;
    logic update;
    logic accum;
    logic div_step;
    logic root_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
  } status_t;

  function automatic int sum_width(input int max_win);
    return 32 + $clog2(max_win);
  endfunction

endpackage

// File: rtl/core/swr_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module swr_ctrl #(
  parameter int DIV_STEPS = 40
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  swr_pkg::status_t status,
  output swr_pkg::cmd_t  cmd
);
  import swr_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_UPDATE,
    S_ACCUM,
    S_DIVIDE,
    S_ROOT,
    S_DELIVER
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.square    = (state == S_SQUARE);
    cmd.update    = (state == S_UPDATE);
    cmd.accum     = (state == S_ACCUM);
    cmd.div_step  = (state == S_DIVIDE);
    cmd.root_step = (state == S_ROOT);
    cmd.out_load  = (state == S_DELIVER) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          cnt <= '0;
          if (status.full) begin
            state <= S_DIVIDE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIVIDE: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROOT: begin
          if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_DELIVER;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DELIVER: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/swr_datapath.sv
// Datapath: sample memory, running square sum, serial divider and square root.
module swr_datapath #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swr_pkg::cmd_t                 cmd,
  output swr_pkg::status_t              status,
  input  logic signed [swr_pkg::SMP_W-1:0] sample,
  input  logic                          start_req,
  input  logic                          cfg_we,
  input  logic [swr_pkg::WIN_W-1:0]     cfg_data,
  output logic [swr_pkg::WIN_W-1:0]     window_size,
  output logic [swr_pkg::RMS_W-1:0]     rms
);
  import swr_pkg::*;

  localparam int SUM_W = sum_width(MAX_WINDOW);
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W = (PTR_W + 1 > WIN_W) ? PTR_W + 1 : WIN_W;
  localparam int WMAX  = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
  localparam logic [WIN_W-1:0] WMAX_V = WIN_W'(WMAX);

  logic [SMP_W-1:0] mem [MAX_WINDOW];

  logic [PTR_W-1:0] wp;
  logic [WIN_W-1:0] fill;
  logic [SUM_W-1:0] sum;
  logic [SMP_W-1:0] smp;
  logic [PTR_W-1:0] cur_ptr;
  logic             was_full;
  logic [SMP_W-1:0] old_data;
  logic [SQ_W-1:0]  sq_new;
  logic [SQ_W-1:0]  sq_old;
  logic [SUM_W-1:0] div_reg;
  logic [WIN_W-1:0] rem;
  logic [16:0]      sq_rem;
  logic [RMS_W-1:0] root;

  logic [WIN_W-1:0] win;
  logic [PTR_W-1:0] wp_start;
  logic [WIN_W-1:0] fill_start;
  logic [PTR_W:0]   wp_inc;
  logic [SUM_W-1:0] sum_add;
  logic [WIN_W:0]   rem_sh;
  logic [18:0]      sq_sh;
  logic [18:0]      sq_trial;

  function automatic logic [SQ_W-1:0] square16(input logic [SMP_W-1:0] v);
    logic [SMP_W:0]     mag;
    logic [2*SMP_W+1:0] prod;
    mag  = v[SMP_W-1] ? ((SMP_W+1)'(1) << SMP_W) - {1'b0, v} : {1'b0, v};
    prod = mag * mag;
    return prod[SQ_W-1:0];
  endfunction

  always_comb begin
    if (window_size == '0) begin
      win = WIN_W'(1);
    end else if (window_size > WMAX_V) begin
      win = WMAX_V;
    end else begin
      win = window_size;
    end
  end

  always_comb begin
    fill_start = start_req ? '0 : fill;
    if (start_req || (CMP_W'(wp) >= CMP_W'(win))) begin
      wp_start = '0;
    end else begin
      wp_start = wp;
    end
  end

  assign wp_inc      = {1'b0, cur_ptr} + 1'b1;
  assign sum_add     = sum + SUM_W'(sq_new);
  assign rem_sh      = {rem, div_reg[SUM_W-1]};
  assign sq_sh       = {sq_rem, div_reg[31:30]};
  assign sq_trial    = {1'b0, root, 2'b01};
  assign status.full = (fill >= win);
  assign rms         = root;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      old_data <= mem[wp_start];
    end
    if (cmd.update) begin
      mem[cur_ptr] <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_RESET;
      wp          <= '0;
      fill        <= '0;
      sum         <= '0;
    end else if (cfg_we) begin
      window_size <= cfg_data;
      wp          <= '0;
      fill        <= '0;
      sum         <= '0;
    end else begin
      if (cmd.accept && start_req) begin
        fill <= '0;
        sum  <= '0;
      end
      if (cmd.update) begin
        if (was_full) begin
          sum <= (sum >= SUM_W'(sq_old)) ? sum - SUM_W'(sq_old) : '0;
        end else begin
          fill <= fill + 1'b1;
        end
        wp <= (CMP_W'(wp_inc) >= CMP_W'(win)) ? '0 : wp_inc[PTR_W-1:0];
      end
      if (cmd.accum) begin
        sum <= sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp      <= sample;
      cur_ptr  <= wp_start;
      was_full <= (fill_start >= win);
    end
    if (cmd.square) begin
      sq_new <= square16(smp);
      sq_old <= square16(old_data);
    end
    if (cmd.accum) begin
      div_reg <= sum_add;
      rem     <= '0;
      sq_rem  <= '0;
      root    <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, win}) begin
        rem     <= WIN_W'(rem_sh - {1'b0, win});
        div_reg <= {div_reg[SUM_W-2:0], 1'b1};
      end else begin
        rem     <= rem_sh[WIN_W-1:0];
        div_reg <= {div_reg[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.root_step) begin
      div_reg <= div_reg << 2;
      if (sq_sh >= sq_trial) begin
        sq_rem <= 17'(sq_sh - sq_trial);
        root   <= {root[RMS_W-2:0], 1'b1};
      end else begin
        sq_rem <= sq_sh[16:0];
        root   <= {root[RMS_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/sliding_window_rms_core.sv
// Top level of the sliding-window RMS core: ports, register port and checks.
//
// Computes floor(sqrt(floor(sum of squares / window))) over the last window_size
// signed Q1.15 samples and returns one unsigned Q1.15 RMS request result per
// sample once the window is full. A request with start_req set clears history
// before its sample is taken; writing window_size clears it too. A request that
// completes a full window takes the sample and reads the oldest entry from the
// sample memory, squares both, updates the running sum, then runs the serial
// divider at one quotient bit per cycle and sixteen two-bit steps of the square
// root, and loads the output register once the previous result has been taken.
// A request that does not yet fill the window returns to idle after the sum
// update and gives no result. The result waits in an output register, so the
// next request may be taken while it is still pending.
`include "assert_macros.svh"

module sliding_window_rms_core #(
  parameter int MAX_WINDOW = swr_pkg::DEF_MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [swr_pkg::SMP_W-1:0]    sample,
  input  logic                                start_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swr_pkg::RMS_W-1:0]           rms,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [swr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [swr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import swr_pkg::*;

  localparam int SUM_W = sum_width(MAX_WINDOW);

  cmd_t             cmd;
  status_t          status;
  logic             cfg_we;
  logic [WIN_W-1:0] window_size;
  logic [RMS_W-1:0] root;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ?
                  {{(APB_DATA_W - WIN_W){1'b0}}, window_size} : '0;

  swr_ctrl #(
    .DIV_STEPS(SUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  swr_datapath #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sample     (sample),
    .start_req  (start_req),
    .cfg_we     (cfg_we),
    .cfg_data   (pwdata[WIN_W-1:0]),
    .window_size(window_size),
    .rms        (root)
  );

  // The result is held in a register loaded only when the controller delivers.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rms <= root;
    end
  end

  `SWR_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `SWR_ASSERT_IMPLY(a_rms_range, clk, rst, out_valid, rms <= 16'h8000)
  `SWR_ASSERT_IMPLY(a_one_command, clk, rst, 1'b1, $onehot0(cmd))

endmodule
